@@ rtl/core/dpfc_pkg.sv @@
// Package for the dual pump fill controller: field types, codes and the
// item, tick, state and result structs. Depends on nothing.
package dpfc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned PeakW  = 10;
  localparam int unsigned GraceW = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [PeakW-1:0]  ThreshReset = PeakW'(100);
  localparam logic [GraceW-1:0] GraceReset  = GraceW'(5000);

  localparam logic [1:0] OhCritical = 2'd0;
  localparam logic [1:0] OhLow      = 2'd1;
  localparam logic [1:0] OhMedium   = 2'd2;
  localparam logic [1:0] OhHigh     = 2'd3;
  localparam logic [1:0] SumpCrit   = 2'd0;
  localparam logic [1:0] SumpLow    = 2'd1;
  localparam logic [1:0] SumpHigh   = 2'd2;

  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_CLR_BORE = 2'd1,
    FUNC_CLR_SUMP = 2'd2
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD = 1'd0,
    CFG_GRACE     = 1'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PUMP_NONE = 2'd0,
    PUMP_BORE = 2'd1,
    PUMP_SUMP = 2'd2
  } pump_e;

  typedef enum logic [2:0] {
    ST_STOPPED  = 3'd0,
    ST_STARTING = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_DRYLOCK  = 3'd3,
    ST_SUMPCRIT = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [TimeW-1:0] now_ms;
    logic [2:0]       overhead_probes;
    logic [1:0]       sump_probes;
    logic             manual_mode;
    logic             emergency_stop;
    logic [1:0]       forced_pump;
    logic             prefer_sump;
    logic             fill_request;
    logic [PeakW-1:0] borewell_current_peak;
    logic [PeakW-1:0] sump_current_peak;
  } item_t;

  typedef struct packed {
    logic [TimeW-1:0]  now;
    logic [1:0]        oh_level;
    logic [1:0]        sump_level;
    logic [PeakW-1:0]  bore_peak;
    logic [PeakW-1:0]  sump_peak;
    logic [PeakW-1:0]  threshold;
    logic [GraceW-1:0] grace;
  } tick_t;

  typedef struct packed {
    pump_e            running;
    status_e          bore_st;
    status_e          sump_st;
    logic             bore_lat;
    logic             sump_lat;
    logic [TimeW-1:0] bore_t0;
    logic [TimeW-1:0] sump_t0;
    logic             fill;
    logic             warn;
    logic             ovr;
  } state_t;

  typedef struct packed {
    logic       borewell_relay;
    logic       sump_relay;
    logic [1:0] active_pump;
    logic [2:0] borewell_status;
    logic [2:0] sump_status;
    logic       fill_active;
    logic       sump_warning;
    logic [1:0] overhead_level;
    logic [1:0] sump_level;
  } res_t;

endpackage

@@ rtl/core/dpfc_if.sv @@
// Channel interfaces of the dual pump fill controller: input items, result
// items and configuration writes. Depends on dpfc_pkg.
interface dpfc_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  func;
  logic [dpfc_pkg::TimeW-1:0]  now_ms;
  logic [2:0]                  overhead_probes;
  logic [1:0]                  sump_probes;
  logic                        manual_mode;
  logic                        emergency_stop;
  logic [1:0]                  forced_pump;
  logic                        prefer_sump;
  logic                        fill_request;
  logic [dpfc_pkg::PeakW-1:0]  borewell_current_peak;
  logic [dpfc_pkg::PeakW-1:0]  sump_current_peak;

  modport source (
    output valid, func, now_ms, overhead_probes, sump_probes, manual_mode,
           emergency_stop, forced_pump, prefer_sump, fill_request,
           borewell_current_peak, sump_current_peak,
    input  ready
  );
  modport sink (
    input  valid, func, now_ms, overhead_probes, sump_probes, manual_mode,
           emergency_stop, forced_pump, prefer_sump, fill_request,
           borewell_current_peak, sump_current_peak,
    output ready
  );
endinterface

interface dpfc_out_if;
  logic       valid;
  logic       ready;
  logic       borewell_relay;
  logic       sump_relay;
  logic [1:0] active_pump;
  logic [2:0] borewell_status;
  logic [2:0] sump_status;
  logic       fill_active;
  logic       sump_warning;
  logic [1:0] overhead_level;
  logic [1:0] sump_level;

  modport source (
    output valid, borewell_relay, sump_relay, active_pump, borewell_status,
           sump_status, fill_active, sump_warning, overhead_level, sump_level,
    input  ready
  );
  modport sink (
    input  valid, borewell_relay, sump_relay, active_pump, borewell_status,
           sump_status, fill_active, sump_warning, overhead_level, sump_level,
    output ready
  );
endinterface

interface dpfc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dpfc_pkg::CfgIdxW-1:0]  index;
  logic [dpfc_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/dpfc_decide.sv @@
// Next-state and result logic for one transaction of the fill controller.
// Purely combinational; depends on dpfc_pkg.
module dpfc_decide (
  input  dpfc_pkg::item_t     item_i,
  input  dpfc_pkg::state_t    state_i,
  input  logic [dpfc_pkg::PeakW-1:0]  threshold_i,
  input  logic [dpfc_pkg::GraceW-1:0] grace_i,
  output dpfc_pkg::state_t    state_o,
  output dpfc_pkg::res_t      res_o
);

  function automatic dpfc_pkg::state_t set_status(dpfc_pkg::state_t s,
                                                  dpfc_pkg::pump_e p,
                                                  dpfc_pkg::status_e v);
    dpfc_pkg::state_t r;
    r = s;
    if (p == dpfc_pkg::PUMP_BORE) begin
      r.bore_st = v;
    end else begin
      r.sump_st = v;
    end
    return r;
  endfunction

  function automatic logic is_locked(dpfc_pkg::state_t s, dpfc_pkg::pump_e p);
    return (p == dpfc_pkg::PUMP_BORE) ? s.bore_lat : s.sump_lat;
  endfunction

  function automatic dpfc_pkg::state_t stop_running(dpfc_pkg::state_t s);
    dpfc_pkg::state_t r;
    r = s;
    if (r.running != dpfc_pkg::PUMP_NONE) begin
      r = set_status(r, r.running, dpfc_pkg::ST_STOPPED);
      r.running = dpfc_pkg::PUMP_NONE;
    end
    return r;
  endfunction

  function automatic dpfc_pkg::state_t try_start(dpfc_pkg::state_t s,
                                                 dpfc_pkg::pump_e p,
                                                 logic chk_sump,
                                                 dpfc_pkg::tick_t t,
                                                 output logic ok);
    dpfc_pkg::state_t r;
    r  = s;
    ok = 1'b0;
    if (is_locked(r, p)) begin
      if (r.running == p) begin
        r = stop_running(r);
      end
    end else if (chk_sump && t.sump_level == dpfc_pkg::SumpCrit) begin
      if (r.running == p) begin
        r = stop_running(r);
      end
      r = set_status(r, p, dpfc_pkg::ST_SUMPCRIT);
    end else if (r.running == p) begin
      ok = 1'b1;
    end else begin
      r = stop_running(r);
      r = set_status(r, p, dpfc_pkg::ST_STARTING);
      if (p == dpfc_pkg::PUMP_BORE) begin
        r.bore_t0 = t.now;
      end else begin
        r.sump_t0 = t.now;
      end
      r.running = p;
      ok = 1'b1;
    end
    return r;
  endfunction

  function automatic dpfc_pkg::state_t check_dry(dpfc_pkg::state_t s,
                                                 dpfc_pkg::tick_t t);
    dpfc_pkg::state_t  r;
    dpfc_pkg::pump_e   p;
    dpfc_pkg::status_e st;
    logic [dpfc_pkg::TimeW-1:0] t0;
    logic [dpfc_pkg::TimeW-1:0] elapsed;
    logic [dpfc_pkg::PeakW-1:0] peak;
    r  = s;
    p  = r.running;
    st = (p == dpfc_pkg::PUMP_BORE) ? r.bore_st : r.sump_st;
    t0 = (p == dpfc_pkg::PUMP_BORE) ? r.bore_t0 : r.sump_t0;
    peak = (p == dpfc_pkg::PUMP_BORE) ? t.bore_peak : t.sump_peak;
    elapsed = t.now - t0;
    if (p != dpfc_pkg::PUMP_NONE &&
        !(st == dpfc_pkg::ST_STARTING &&
          elapsed < {{(dpfc_pkg::TimeW-dpfc_pkg::GraceW){1'b0}}, t.grace})) begin
      if (peak > t.threshold) begin
        r = set_status(r, p, dpfc_pkg::ST_RUNNING);
      end else begin
        r = stop_running(r);
        r = set_status(r, p, dpfc_pkg::ST_DRYLOCK);
        if (p == dpfc_pkg::PUMP_BORE) begin
          r.bore_lat = 1'b1;
        end else begin
          r.sump_lat = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic dpfc_pkg::state_t select_auto(dpfc_pkg::state_t s,
                                                   logic pref_sump,
                                                   dpfc_pkg::tick_t t);
    dpfc_pkg::state_t r;
    logic ok;
    if (pref_sump) begin
      r = try_start(s, dpfc_pkg::PUMP_SUMP, 1'b1, t, ok);
      if (!ok) begin
        r = try_start(r, dpfc_pkg::PUMP_BORE, 1'b0, t, ok);
      end
    end else begin
      r = try_start(s, dpfc_pkg::PUMP_BORE, 1'b0, t, ok);
      if (!ok) begin
        r = try_start(r, dpfc_pkg::PUMP_SUMP, 1'b1, t, ok);
      end
    end
    if (!ok) begin
      if (r.bore_lat) begin
        r.bore_st = dpfc_pkg::ST_DRYLOCK;
      end
      if (r.sump_lat && r.sump_st != dpfc_pkg::ST_SUMPCRIT) begin
        r.sump_st = dpfc_pkg::ST_DRYLOCK;
      end
    end
    return r;
  endfunction

  function automatic dpfc_pkg::state_t run_manual(dpfc_pkg::state_t s,
                                                  logic estop,
                                                  logic [1:0] forced,
                                                  dpfc_pkg::tick_t t);
    dpfc_pkg::state_t r;
    logic ok;
    if (estop || (forced != dpfc_pkg::PUMP_BORE && forced != dpfc_pkg::PUMP_SUMP)) begin
      r = stop_running(s);
    end else begin
      r = try_start(s, dpfc_pkg::pump_e'(forced), 1'b0, t, ok);
      if (ok) begin
        r = check_dry(r, t);
      end
    end
    return r;
  endfunction

  function automatic dpfc_pkg::state_t run_auto(dpfc_pkg::state_t s,
                                                logic estop,
                                                logic pref_sump,
                                                dpfc_pkg::tick_t t);
    dpfc_pkg::state_t r;
    dpfc_pkg::pump_e  pref;
    logic wrong;
    logic avail;
    r = s;
    pref = pref_sump ? dpfc_pkg::PUMP_SUMP : dpfc_pkg::PUMP_BORE;
    if (estop) begin
      r = stop_running(r);
      r.fill = 1'b0;
    end else begin
      if (t.sump_level == dpfc_pkg::SumpCrit) begin
        r.warn = 1'b1;
        if (r.running == dpfc_pkg::PUMP_SUMP) begin
          r = stop_running(r);
          r.sump_st = dpfc_pkg::ST_SUMPCRIT;
        end
      end
      if (t.oh_level <= dpfc_pkg::OhLow) begin
        r.fill = 1'b1;
      end
      if (!(r.ovr || r.fill)) begin
        r = stop_running(r);
      end else if (t.oh_level == dpfc_pkg::OhHigh) begin
        r = stop_running(r);
        r.fill = 1'b0;
        r.ovr  = 1'b0;
      end else begin
        wrong = (pref_sump && r.running == dpfc_pkg::PUMP_BORE) ||
                (!pref_sump && r.running == dpfc_pkg::PUMP_SUMP);
        avail = !is_locked(r, pref) &&
                !(pref_sump && t.sump_level == dpfc_pkg::SumpCrit);
        if (wrong && avail) begin
          r = stop_running(r);
        end
        if (r.running == dpfc_pkg::PUMP_NONE) begin
          r = select_auto(r, pref_sump, t);
        end
        r = check_dry(r, t);
        if (r.running == dpfc_pkg::PUMP_NONE) begin
          r = select_auto(r, pref_sump, t);
        end
      end
    end
    return r;
  endfunction

  dpfc_pkg::tick_t  tick;
  dpfc_pkg::state_t nxt;

  always_comb begin
    tick.now = item_i.now_ms;
    if (item_i.overhead_probes[2]) begin
      tick.oh_level = dpfc_pkg::OhHigh;
    end else if (item_i.overhead_probes[1]) begin
      tick.oh_level = dpfc_pkg::OhMedium;
    end else if (item_i.overhead_probes[0]) begin
      tick.oh_level = dpfc_pkg::OhLow;
    end else begin
      tick.oh_level = dpfc_pkg::OhCritical;
    end
    if (item_i.sump_probes[1]) begin
      tick.sump_level = dpfc_pkg::SumpHigh;
    end else if (item_i.sump_probes[0]) begin
      tick.sump_level = dpfc_pkg::SumpLow;
    end else begin
      tick.sump_level = dpfc_pkg::SumpCrit;
    end
    tick.bore_peak = item_i.borewell_current_peak;
    tick.sump_peak = item_i.sump_current_peak;
    tick.threshold = threshold_i;
    tick.grace     = grace_i;
  end

  always_comb begin
    nxt = state_i;
    case (item_i.func)
      dpfc_pkg::FUNC_TICK: begin
        if (item_i.fill_request) begin
          nxt.ovr = 1'b1;
        end
        if (item_i.manual_mode) begin
          nxt = run_manual(nxt, item_i.emergency_stop, item_i.forced_pump, tick);
        end else begin
          nxt = run_auto(nxt, item_i.emergency_stop, item_i.prefer_sump, tick);
        end
      end
      dpfc_pkg::FUNC_CLR_BORE: begin
        nxt.bore_lat = 1'b0;
        nxt.bore_st  = dpfc_pkg::ST_STOPPED;
      end
      dpfc_pkg::FUNC_CLR_SUMP: begin
        nxt.sump_lat = 1'b0;
        nxt.sump_st  = dpfc_pkg::ST_STOPPED;
      end
      default: begin
        nxt = state_i;
      end
    endcase
  end

  assign state_o = nxt;

  always_comb begin
    res_o.borewell_relay  = (nxt.running == dpfc_pkg::PUMP_BORE);
    res_o.sump_relay      = (nxt.running == dpfc_pkg::PUMP_SUMP);
    res_o.active_pump     = nxt.running;
    res_o.borewell_status = nxt.bore_st;
    res_o.sump_status     = nxt.sump_st;
    res_o.fill_active     = nxt.fill;
    res_o.sump_warning    = nxt.warn;
    res_o.overhead_level  = tick.oh_level;
    res_o.sump_level      = tick.sump_level;
  end

endmodule

@@ rtl/core/dual_pump_fill_controller_unit.sv @@
// Dual pump fill controller top level: input, state, configuration and result
// registers around dpfc_decide. Depends on dpfc_pkg, dpfc_if and dpfc_decide.
// An accepted transaction is held in the input register, decided by dpfc_decide, and
// its result and new state are registered when the result register can advance.
// Throughput: one transaction per cycle while the result port is ready.
// Reset: asynchronous, active low; pumps stopped, latches clear, threshold 100, grace 5000 ms.
module dual_pump_fill_controller_unit (
  input  logic clk_i,
  input  logic rst_ni,
  dpfc_in_if.sink    in_i,
  dpfc_out_if.source out_o,
  dpfc_cfg_if.sink   cfg_i
);

  dpfc_pkg::item_t  item_q;
  logic             in_vld_q;
  dpfc_pkg::state_t state_q;
  dpfc_pkg::state_t state_d;
  dpfc_pkg::res_t   res_q;
  dpfc_pkg::res_t   res_d;
  logic             out_vld_q;
  logic [dpfc_pkg::PeakW-1:0]  thresh_q;
  logic [dpfc_pkg::GraceW-1:0] grace_q;
  logic             adv;
  logic             fire;

  assign adv        = !out_vld_q || out_o.ready;
  assign fire       = in_vld_q && adv;
  assign in_i.ready = !in_vld_q || adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= dpfc_pkg::ThreshReset;
      grace_q  <= dpfc_pkg::GraceReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        dpfc_pkg::CFG_THRESHOLD: thresh_q <= cfg_i.data[dpfc_pkg::PeakW-1:0];
        dpfc_pkg::CFG_GRACE:     grace_q  <= cfg_i.data[dpfc_pkg::GraceW-1:0];
        default: begin
          thresh_q <= thresh_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q.func                  <= in_i.func;
      item_q.now_ms                <= in_i.now_ms;
      item_q.overhead_probes       <= in_i.overhead_probes;
      item_q.sump_probes           <= in_i.sump_probes;
      item_q.manual_mode           <= in_i.manual_mode;
      item_q.emergency_stop        <= in_i.emergency_stop;
      item_q.forced_pump           <= in_i.forced_pump;
      item_q.prefer_sump           <= in_i.prefer_sump;
      item_q.fill_request          <= in_i.fill_request;
      item_q.borewell_current_peak <= in_i.borewell_current_peak;
      item_q.sump_current_peak     <= in_i.sump_current_peak;
    end
  end

  dpfc_decide u_decide (
    .item_i      (item_q),
    .state_i     (state_q),
    .threshold_i (thresh_q),
    .grace_i     (grace_q),
    .state_o     (state_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.running  <= dpfc_pkg::PUMP_NONE;
      state_q.bore_st  <= dpfc_pkg::ST_STOPPED;
      state_q.sump_st  <= dpfc_pkg::ST_STOPPED;
      state_q.bore_lat <= 1'b0;
      state_q.sump_lat <= 1'b0;
      state_q.bore_t0  <= '0;
      state_q.sump_t0  <= '0;
      state_q.fill     <= 1'b0;
      state_q.warn     <= 1'b0;
      state_q.ovr      <= 1'b0;
      out_vld_q        <= 1'b0;
    end else if (fire) begin
      state_q   <= state_d;
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.borewell_relay  = res_q.borewell_relay;
  assign out_o.sump_relay      = res_q.sump_relay;
  assign out_o.active_pump     = res_q.active_pump;
  assign out_o.borewell_status = res_q.borewell_status;
  assign out_o.sump_status     = res_q.sump_status;
  assign out_o.fill_active     = res_q.fill_active;
  assign out_o.sump_warning    = res_q.sump_warning;
  assign out_o.overhead_level  = res_q.overhead_level;
  assign out_o.sump_level      = res_q.sump_level;

  a_relays_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(res_q.borewell_relay && res_q.sump_relay))
    else $error("both pump relays on");

  a_relay_matches_pump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (res_q.borewell_relay == (res_q.active_pump == dpfc_pkg::PUMP_BORE)) &&
                  (res_q.sump_relay == (res_q.active_pump == dpfc_pkg::PUMP_SUMP)))
    else $error("relay outputs disagree with active pump");

  a_state_pump_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.running != 2'd3)
    else $error("running pump holds an unused code");

  a_stalled_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> in_vld_q && $stable(item_q) && $stable(state_q))
    else $error("stalled item or state changed");

endmodule

@@ verif/tb_dual_pump_fill_controller_unit.sv @@
// Self-checking testbench for the dual pump fill controller: directed, configuration,
// back-pressure and random control tick tests, with results checked against a predictor.
// Depends on dpfc_pkg, the dpfc channel interfaces and dual_pump_fill_controller_unit.
module tb_dual_pump_fill_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import dpfc_pkg::*;

  localparam logic [1:0]  FuncUnused = 2'd3;
  localparam logic [1:0]  PumpBogus  = 2'd3;
  localparam int unsigned HoldLen    = 300;
  localparam int unsigned QuietLimit = 3000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dpfc_in_if  in_ch ();
  dpfc_out_if out_ch ();
  dpfc_cfg_if cfg_ch ();

  dual_pump_fill_controller_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always #2 clk_i = ~clk_i;

  pump_e             pump_on;
  status_e           bore_st;
  status_e           sump_st;
  logic              bore_lock;
  logic              sump_lock;
  logic [TimeW-1:0]  bore_t0;
  logic [TimeW-1:0]  sump_t0;
  logic              fill_on;
  logic              warn_seen;
  logic              fill_req_hold;
  logic [PeakW-1:0]  thresh;
  logic [GraceW-1:0] grace;

  logic [TimeW-1:0]  tk_now;
  logic [1:0]        tk_oh;
  logic [1:0]        tk_sl;
  logic [PeakW-1:0]  tk_bpk;
  logic [PeakW-1:0]  tk_spk;

  res_t              due_reports[$];
  int unsigned       fault_count = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       hold_asks = 0;
  logic              sink_throttle = 1'b0;

  int unsigned       tank_fill = 0;
  logic [TimeW-1:0]  now_cursor = '0;
  logic              pref_sticky = 1'b0;

  function automatic void set_status(pump_e p, status_e s);
    if (p == PUMP_BORE) bore_st = s;
    else sump_st = s;
  endfunction

  function automatic status_e status_of(pump_e p);
    if (p == PUMP_BORE) return bore_st;
    return sump_st;
  endfunction

  function automatic logic is_locked(pump_e p);
    return (p == PUMP_BORE) ? bore_lock : sump_lock;
  endfunction

  function automatic void halt_pump();
    if (pump_on == PUMP_NONE) return;
    set_status(pump_on, ST_STOPPED);
    pump_on = PUMP_NONE;
  endfunction

  function automatic logic try_pump(pump_e p, logic sump_chk);
    if (is_locked(p)) begin
      if (pump_on == p) halt_pump();
      return 1'b0;
    end
    if (sump_chk && tk_sl == SumpCrit) begin
      if (pump_on == p) halt_pump();
      set_status(p, ST_SUMPCRIT);
      return 1'b0;
    end
    if (pump_on == p) return 1'b1;
    halt_pump();
    set_status(p, ST_STARTING);
    if (p == PUMP_BORE) bore_t0 = tk_now;
    else sump_t0 = tk_now;
    pump_on = p;
    return 1'b1;
  endfunction

  function automatic void check_flow();
    pump_e            p;
    logic [TimeW-1:0] elapsed;
    logic [PeakW-1:0] peak;
    p = pump_on;
    if (p == PUMP_NONE) return;
    elapsed = tk_now - ((p == PUMP_BORE) ? bore_t0 : sump_t0);
    peak = (p == PUMP_BORE) ? tk_bpk : tk_spk;
    if (status_of(p) == ST_STARTING && elapsed < grace) return;
    if (peak > thresh) begin
      set_status(p, ST_RUNNING);
      return;
    end
    halt_pump();
    set_status(p, ST_DRYLOCK);
    if (p == PUMP_BORE) bore_lock = 1'b1;
    else sump_lock = 1'b1;
  endfunction

  function automatic void pick_auto(logic pref);
    if (pref) begin
      if (try_pump(PUMP_SUMP, 1'b1)) return;
      if (try_pump(PUMP_BORE, 1'b0)) return;
    end else begin
      if (try_pump(PUMP_BORE, 1'b0)) return;
      if (try_pump(PUMP_SUMP, 1'b1)) return;
    end
    if (bore_lock) bore_st = ST_DRYLOCK;
    if (sump_lock && sump_st != ST_SUMPCRIT) sump_st = ST_DRYLOCK;
  endfunction

  function automatic void run_manual(logic es, logic [1:0] forced);
    if (es || (forced != PUMP_BORE && forced != PUMP_SUMP)) begin
      halt_pump();
      return;
    end
    if (!try_pump(pump_e'(forced), 1'b0)) return;
    check_flow();
  endfunction

  function automatic void run_auto(logic es, logic pref);
    pump_e want;
    if (es) begin
      halt_pump();
      fill_on = 1'b0;
      return;
    end
    if (tk_sl == SumpCrit) begin
      warn_seen = 1'b1;
      if (pump_on == PUMP_SUMP) begin
        halt_pump();
        sump_st = ST_SUMPCRIT;
      end
    end
    if (tk_oh <= OhLow) fill_on = 1'b1;
    if (!(fill_req_hold || fill_on)) begin
      halt_pump();
      return;
    end
    if (tk_oh == OhHigh) begin
      halt_pump();
      fill_on = 1'b0;
      fill_req_hold = 1'b0;
      return;
    end
    if (pref) want = PUMP_SUMP;
    else want = PUMP_BORE;
    if (pump_on != PUMP_NONE && pump_on != want) begin
      if (!is_locked(want) && !(pref && tk_sl == SumpCrit)) halt_pump();
    end
    if (pump_on == PUMP_NONE) pick_auto(pref);
    check_flow();
    if (pump_on == PUMP_NONE) pick_auto(pref);
  endfunction

  function automatic res_t step_controller(item_t it);
    res_t r;
    tk_now = it.now_ms;
    tk_oh = it.overhead_probes[2] ? OhHigh : it.overhead_probes[1] ? OhMedium :
            it.overhead_probes[0] ? OhLow : OhCritical;
    tk_sl = it.sump_probes[1] ? SumpHigh : it.sump_probes[0] ? SumpLow : SumpCrit;
    tk_bpk = it.borewell_current_peak;
    tk_spk = it.sump_current_peak;
    case (it.func)
      FUNC_TICK: begin
        if (it.fill_request) fill_req_hold = 1'b1;
        if (it.manual_mode) run_manual(it.emergency_stop, it.forced_pump);
        else run_auto(it.emergency_stop, it.prefer_sump);
      end
      FUNC_CLR_BORE: begin
        bore_lock = 1'b0;
        bore_st = ST_STOPPED;
      end
      FUNC_CLR_SUMP: begin
        sump_lock = 1'b0;
        sump_st = ST_STOPPED;
      end
      default: ;
    endcase
    r.borewell_relay  = (pump_on == PUMP_BORE);
    r.sump_relay      = (pump_on == PUMP_SUMP);
    r.active_pump     = pump_on;
    r.borewell_status = bore_st;
    r.sump_status     = sump_st;
    r.fill_active     = fill_on;
    r.sump_warning    = warn_seen;
    r.overhead_level  = tk_oh;
    r.sump_level      = tk_sl;
    return r;
  endfunction

  function automatic void reset_controller();
    pump_on = PUMP_NONE;
    bore_st = ST_STOPPED;
    sump_st = ST_STOPPED;
    bore_lock = 1'b0;
    sump_lock = 1'b0;
    bore_t0 = '0;
    sump_t0 = '0;
    fill_on = 1'b0;
    warn_seen = 1'b0;
    fill_req_hold = 1'b0;
    thresh = ThreshReset;
    grace = GraceReset;
  endfunction

  function automatic item_t make_item(logic [1:0] fn, logic [TimeW-1:0] now,
                                      logic [2:0] ohp, logic [1:0] sp, logic man,
                                      logic es, logic [1:0] fp, logic pref, logic fr,
                                      logic [PeakW-1:0] bpk, logic [PeakW-1:0] spk);
    item_t it;
    it.func = fn;
    it.now_ms = now;
    it.overhead_probes = ohp;
    it.sump_probes = sp;
    it.manual_mode = man;
    it.emergency_stop = es;
    it.forced_pump = fp;
    it.prefer_sump = pref;
    it.fill_request = fr;
    it.borewell_current_peak = bpk;
    it.sump_current_peak = spk;
    return it;
  endfunction

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [PeakW-1:0] pick_peak();
    int r;
    r = $urandom_range(0, 99);
    if (r < 72 && thresh < 512) return PeakW'($urandom_range(thresh + 1, 512));
    if (r < 94) return PeakW'($urandom_range(0, thresh));
    return PeakW'($urandom_range(0, 1023));
  endfunction

  // Tank level follows the pump so that fill cycles run from low to high and back.
  function automatic item_t rand_item();
    item_t it;
    int    r;
    r = $urandom_range(0, 99);
    it.func = (r < 88) ? FUNC_TICK : (r < 93) ? FUNC_CLR_BORE :
              (r < 98) ? FUNC_CLR_SUMP : FuncUnused;
    if ($urandom_range(0, 49) == 0) now_cursor = $urandom();
    else now_cursor = now_cursor + $urandom_range(0, 2500);
    it.now_ms = now_cursor;
    if (pump_on != PUMP_NONE && tank_fill < 3 && $urandom_range(0, 3) == 0) tank_fill++;
    else if (pump_on == PUMP_NONE && tank_fill > 0 && $urandom_range(0, 5) == 0) tank_fill--;
    if ($urandom_range(0, 9) == 0) it.overhead_probes = 3'($urandom_range(0, 7));
    else it.overhead_probes = 3'((1 << tank_fill) - 1);
    r = $urandom_range(0, 99);
    it.sump_probes = (r < 70) ? 2'b11 : (r < 85) ? 2'b01 : (r < 95) ? 2'b00 : 2'b10;
    it.manual_mode = ($urandom_range(0, 99) < 15);
    it.emergency_stop = ($urandom_range(0, 99) < 4);
    it.forced_pump = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 8) pref_sticky = ~pref_sticky;
    it.prefer_sump = pref_sticky;
    it.fill_request = ($urandom_range(0, 99) < 4);
    it.borewell_current_peak = pick_peak();
    it.sump_current_peak = pick_peak();
    return it;
  endfunction

  task automatic drive_fields(item_t it);
    in_ch.func <= it.func;
    in_ch.now_ms <= it.now_ms;
    in_ch.overhead_probes <= it.overhead_probes;
    in_ch.sump_probes <= it.sump_probes;
    in_ch.manual_mode <= it.manual_mode;
    in_ch.emergency_stop <= it.emergency_stop;
    in_ch.forced_pump <= it.forced_pump;
    in_ch.prefer_sump <= it.prefer_sump;
    in_ch.fill_request <= it.fill_request;
    in_ch.borewell_current_peak <= it.borewell_current_peak;
    in_ch.sump_current_peak <= it.sump_current_peak;
  endtask

  task automatic send_item(item_t it);
    drive_fields(it);
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    due_reports.push_back(step_controller(it));
  endtask

  task automatic idle_source(int unsigned n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (due_reports.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    if (idx == CFG_THRESHOLD) thresh = val[PeakW-1:0];
    else grace = val;
  endtask

  task automatic set_config(logic [CfgDataW-1:0] th, logic [CfgDataW-1:0] gr);
    settle();
    write_reg(CFG_THRESHOLD, th);
    write_reg(CFG_GRACE, gr);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_item(make_item(FUNC_TICK, 32'd0, 3'b000, 2'b11, 0, 0, PUMP_NONE, 0, 0, 0, 0));
    send_item(make_item(FUNC_TICK, 32'd6000, 3'b001, 2'b11, 0, 0, PUMP_NONE, 0, 0, 50, 0));
    send_item(make_item(FUNC_TICK, 32'd6001, 3'b001, 2'b11, 0, 0, PUMP_NONE, 0, 0, 0, 1023));
    send_item(make_item(FUNC_TICK, 32'd12000, 3'b011, 2'b11, 0, 0, PUMP_NONE, 0, 0, 0, 101));
    send_item(make_item(FUNC_TICK, 32'd12100, 3'b011, 2'b00, 0, 0, PUMP_NONE, 0, 0, 0, 200));
    send_item(make_item(FUNC_CLR_BORE, 32'd12200, 3'b101, 2'b10, 0, 0, PUMP_NONE, 0, 0, 0, 0));
    send_item(make_item(FuncUnused, 32'd12250, 3'b010, 2'b01, 1, 1, PumpBogus, 1, 1, 0, 0));
    send_item(make_item(FUNC_TICK, 32'd12300, 3'b111, 2'b11, 0, 0, PUMP_NONE, 0, 1, 0, 0));
    send_item(make_item(FUNC_TICK, 32'd12400, 3'b011, 2'b11, 0, 0, PUMP_NONE, 1, 1, 0, 0));
    send_item(make_item(FUNC_TICK, 32'd12500, 3'b011, 2'b11, 0, 1, PUMP_NONE, 0, 0, 0, 0));
    send_item(make_item(FUNC_TICK, 32'd13000, 3'b011, 2'b11, 1, 0, PUMP_BORE, 0, 0, 300, 0));
    send_item(make_item(FUNC_TICK, 32'd13100, 3'b011, 2'b11, 1, 0, PumpBogus, 0, 0, 300, 0));
    send_item(make_item(FUNC_TICK, 32'd13200, 3'b011, 2'b11, 1, 1, PUMP_SUMP, 0, 0, 0, 300));
    send_item(make_item(FUNC_TICK, 32'd14000, 3'b011, 2'b11, 1, 0, PUMP_SUMP, 0, 0, 0, 512));
    send_item(make_item(FUNC_CLR_SUMP, 32'd14100, 3'b000, 2'b00, 0, 0, PUMP_NONE, 0, 0, 0, 0));
    send_item(make_item(FUNC_TICK, 32'hFFFF_FFFF, 3'b011, 2'b11, 1, 0, PUMP_BORE, 0, 0, 0, 0));
    send_item(make_item(FUNC_TICK, 32'h0000_1000, 3'b011, 2'b11, 1, 0, PUMP_BORE, 0, 0, 0, 0));
    send_item(make_item(FUNC_TICK, 32'd5000, 3'b011, 2'b11, 1, 0, PUMP_BORE, 0, 0, 0, 0));
    send_item(make_item(FUNC_TICK, 32'd5100, 3'b011, 2'b11, 1, 0, PUMP_BORE, 0, 0, 1023, 0));
    send_item(make_item(FUNC_CLR_BORE, 32'd5200, 3'b011, 2'b11, 0, 0, PUMP_NONE, 0, 0, 0, 0));
    send_item(make_item(FUNC_TICK, 32'd5300, 3'b000, 2'b01, 0, 0, PUMP_NONE, 1, 0, 0, 0));
  endtask

  task automatic test_config_extremes();
    set_config(16'd0, 16'd0);
    send_item(make_item(FUNC_CLR_BORE, 32'd90, 3'b011, 2'b11, 0, 0, PUMP_NONE, 0, 0, 0, 0));
    send_item(make_item(FUNC_CLR_SUMP, 32'd95, 3'b011, 2'b11, 0, 0, PUMP_NONE, 0, 0, 0, 0));
    send_item(make_item(FUNC_TICK, 32'd100, 3'b011, 2'b11, 1, 0, PUMP_BORE, 0, 0, 0, 0));
    send_item(make_item(FUNC_CLR_BORE, 32'd100, 3'b011, 2'b11, 0, 0, PUMP_NONE, 0, 0, 0, 0));
    send_item(make_item(FUNC_TICK, 32'd101, 3'b011, 2'b11, 1, 0, PUMP_BORE, 0, 0, 1, 0));
    set_config(16'd512, 16'hFFFF);
    send_item(make_item(FUNC_TICK, 32'd200, 3'b011, 2'b11, 1, 0, PUMP_SUMP, 0, 0, 0, 512));
    send_item(make_item(FUNC_TICK, 32'd65734, 3'b011, 2'b11, 1, 0, PUMP_SUMP, 0, 0, 0, 512));
    send_item(make_item(FUNC_TICK, 32'd65735, 3'b011, 2'b11, 1, 0, PUMP_SUMP, 0, 0, 0, 513));
    send_item(make_item(FUNC_TICK, 32'd65800, 3'b011, 2'b11, 1, 0, PUMP_SUMP, 0, 0, 0, 512));
    send_item(make_item(FUNC_CLR_SUMP, 32'd65900, 3'b011, 2'b11, 0, 0, PUMP_NONE, 0, 0, 0, 0));
  endtask

  task automatic test_backpressure();
    set_config(16'd100, 16'd5000);
    sink_throttle <= 1'b0;
    hold_asks <= hold_asks + 1;
    repeat (40) send_item(rand_item());
  endtask

  task automatic test_drain_pause();
    sink_throttle <= 1'b1;
    repeat (30) send_item(rand_item());
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (due_reports.size() != 0);
    repeat (30) send_item(rand_item());
  endtask

  task automatic test_random_traffic();
    logic calm;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) set_config(16'd0, 16'd0);
      else if (ph == 1) set_config(16'd512, 16'hFFFF);
      else set_config(CfgDataW'($urandom_range(0, 512)), CfgDataW'($urandom_range(0, 8000)));
      for (int k = 0; k < 150; k++) begin
        if (k % 50 == 0) begin
          calm = ($urandom_range(0, 3) == 0);
          sink_throttle <= ~calm;
        end
        send_item(rand_item());
        if (!calm && $urandom_range(0, 4) == 0) idle_source(gap_len());
      end
    end
  endtask

  function automatic void note_fault(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= 10)
        $display("mismatch on %s at %0t: expected %0h, actual %0h", what, $time, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (due_reports.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("result at %0t with no transaction pending", $time);
      end else begin
        want = due_reports.pop_front();
        note_fault("borewell_relay", 32'(want.borewell_relay), 32'(out_ch.borewell_relay));
        note_fault("sump_relay", 32'(want.sump_relay), 32'(out_ch.sump_relay));
        note_fault("active_pump", 32'(want.active_pump), 32'(out_ch.active_pump));
        note_fault("borewell_status", 32'(want.borewell_status),
                   32'(out_ch.borewell_status));
        note_fault("sump_status", 32'(want.sump_status), 32'(out_ch.sump_status));
        note_fault("fill_active", 32'(want.fill_active), 32'(out_ch.fill_active));
        note_fault("sump_warning", 32'(want.sump_warning), 32'(out_ch.sump_warning));
        note_fault("overhead_level", 32'(want.overhead_level), 32'(out_ch.overhead_level));
        note_fault("sump_level", 32'(want.sump_level), 32'(out_ch.sump_level));
      end
    end
  end

  initial begin
    int unsigned hold_served;
    int unsigned hold_left;
    int unsigned stall_left;
    hold_served = 0;
    hold_left = 0;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asks != hold_served) begin
        hold_served = hold_asks;
        hold_left = HoldLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!sink_throttle) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = gap_len() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    reset_controller();
    drive_fields('0);
    in_ch.valid <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_THRESHOLD;
    cfg_ch.data <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_drain_pause();
    test_random_traffic();
    settle();
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/dpfc_pkg.sv
rtl/core/dpfc_if.sv
rtl/core/dpfc_decide.sv
rtl/core/dual_pump_fill_controller_unit.sv
verif/tb_dual_pump_fill_controller_unit.sv
